@@ rtl/lcar_pkg.sv @@
`default_nettype none
package lcar_pkg;

   // fixed field widths
   localparam int REQ_TYPE_W   = 2;
   localparam int SCALE_W      = 24;
   localparam int HALF_W       = 8;
   localparam int RAW_W        = 24;
   localparam int FORCE_W      = 28;
   localparam int ADC_BITS_DEF = 24;

   // register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);
   localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(1);

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TARE = 2'd2;

   // register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF  = 1'b1;

   // serial interface status after one tick
   typedef struct packed {
      logic sck;
      logic busy;
      logic finish;
      logic kind;   // 1 tare capture, 0 force read
   } lcar_status_type;

endpackage
`default_nettype wire

@@ rtl/lcar_serial.sv @@
`default_nettype none
module lcar_serial #(
   parameter int ADC_BITS = lcar_pkg::ADC_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               step,
   input  wire [lcar_pkg::REQ_TYPE_W-1:0]    req_type,
   input  wire                               dout_level,
   input  wire [lcar_pkg::HALF_W-1:0]        half_ticks,
   output lcar_pkg::lcar_status_type         status,
   output logic [ADC_BITS-1:0]               word
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;
   localparam logic [1:0] PH_LOW  = 2'd3;
   localparam int BIT_W = $clog2(ADC_BITS + 2);
   localparam logic [ADC_BITS-1:0] SIGN_FLIP = {1'b1, {(ADC_BITS-1){1'b0}}};

   logic [1:0]                    phase_ff, phase_in;
   logic                          kind_ff, kind_in;
   logic [BIT_W-1:0]              bit_ff, bit_in;
   logic [lcar_pkg::HALF_W-1:0]   tick_ff, tick_in;
   logic [ADC_BITS-1:0]           shift_ff, shift_in;
   logic [lcar_pkg::HALF_W-1:0]   half;
   logic                          finish;

   always_comb begin
      half     = (half_ticks == '0) ? lcar_pkg::HALF_W'(1) : half_ticks;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      finish   = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (req_type == lcar_pkg::REQ_READ || req_type == lcar_pkg::REQ_TARE) begin
               kind_in  = (req_type == lcar_pkg::REQ_TARE);
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!dout_level) begin
               phase_in = PH_HIGH;
               tick_in  = lcar_pkg::HALF_W'(1);
               bit_in   = '0;
               shift_in = '0;
            end
         end
         PH_HIGH: begin
            if (tick_ff >= half) begin
               phase_in = PH_LOW;
               tick_in  = lcar_pkg::HALF_W'(1);
            end else begin
               tick_in = tick_ff + lcar_pkg::HALF_W'(1);
            end
         end
         PH_LOW: begin
            if (tick_ff >= half) begin
               // sample after the falling edge
               if (bit_ff < BIT_W'(ADC_BITS)) begin
                  shift_in = {shift_ff[ADC_BITS-2:0], dout_level};
               end
               if (bit_ff == BIT_W'(ADC_BITS)) begin
                  // end of the extra pulse
                  finish   = 1'b1;
                  phase_in = PH_IDLE;
                  bit_in   = '0;
                  tick_in  = '0;
               end else begin
                  bit_in   = bit_ff + BIT_W'(1);
                  phase_in = PH_HIGH;
                  tick_in  = lcar_pkg::HALF_W'(1);
               end
            end else begin
               tick_in = tick_ff + lcar_pkg::HALF_W'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= 1'b0;
         bit_ff   <= '0;
         tick_ff  <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
      end
   end

   assign status.sck    = (phase_in == PH_HIGH);
   assign status.busy   = (phase_in != PH_IDLE);
   assign status.finish = finish;
   assign status.kind   = kind_ff;
   assign word          = shift_ff ^ SIGN_FLIP;

endmodule
`default_nettype wire

@@ rtl/lcar_div.sv @@
`default_nettype none
module lcar_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 25
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire [NUM_W-1:0]  num,
   input  wire [DEN_W-1:0]  den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;

   // one restoring step per cycle, numerator bits shift out of q as quotient bits shift in
   always_comb begin
      rem_shift = {rem_ff, q_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!rem_diff[DEN_W]) begin
            rem_in = rem_diff[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule
`default_nettype wire

@@ rtl/load_cell_adc_reader_with_tare.sv @@
// a tick's result stands in the output register the cycle after its transfer; the
// tick that ends a force read waits for the bit-serial divider, one quotient bit a cycle, and
// has its result registered once the divider reports done
// one tick per cycle while the output register can drain; req_tready stays low while the
// divider runs, so no tick enters after a force read until the divide has finished
// reset: synchronous active high; idle, tare/result/error cleared, scale 1000, half period 1
`default_nettype none
module load_cell_adc_reader_with_tare #(
   parameter int ADC_BITS = lcar_pkg::ADC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // tick channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [7:0]                           req_tdata,  // [0] dout_level, [7:1] zero
   input  wire [lcar_pkg::REQ_TYPE_W-1:0]      req_tuser,  // [1:0] req_type
   // result channel
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [0] sck_level, [1] busy_res, [2] result_valid, [3] tare_done, [27:4] raw_code,
   // [55:28] force_res, [56] weight_error, [63:57] zero
   output logic [63:0]                         rsp_tdata,
   // register writes
   input  wire                                 csr_we,
   input  wire [lcar_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire [lcar_pkg::SCALE_W-1:0]         csr_wdata
);

   // numerator net*20 + scale must fit, plus one bit of headroom
   localparam int NUM_W = ((ADC_BITS + 5 > lcar_pkg::SCALE_W) ? ADC_BITS + 5
                                                               : lcar_pkg::SCALE_W) + 1;
   localparam int DEN_W = lcar_pkg::SCALE_W + 1;
   localparam int QX_W  = (NUM_W > lcar_pkg::FORCE_W) ? NUM_W : lcar_pkg::FORCE_W;
   localparam int RAW_X = (ADC_BITS > lcar_pkg::RAW_W) ? ADC_BITS : lcar_pkg::RAW_W;

   // sequencer codes
   localparam logic [1:0] S_RUN  = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [lcar_pkg::SCALE_W-1:0]    scale_ff;
   logic [lcar_pkg::HALF_W-1:0]     half_ff;
   logic [ADC_BITS-1:0]             tare_ff;
   logic [lcar_pkg::RAW_W-1:0]      last_raw_ff;
   logic [lcar_pkg::FORCE_W-1:0]    last_force_ff;
   logic                            error_ff;
   logic [ADC_BITS-1:0]             net_ff;
   logic                            below_ff;

   // output register
   logic                            rsp_valid_ff;
   logic                            rsp_sck_ff, rsp_busy_ff, rsp_done_ff, rsp_tared_ff;
   logic [lcar_pkg::RAW_W-1:0]      rsp_raw_ff;
   logic [lcar_pkg::FORCE_W-1:0]    rsp_force_ff;
   logic                            rsp_err_ff;

   logic                            req_accept;
   lcar_pkg::lcar_status_type       status;
   logic [ADC_BITS-1:0]             word;
   logic [RAW_X-1:0]                word_x;
   logic [lcar_pkg::RAW_W-1:0]      word_raw;
   logic [lcar_pkg::SCALE_W-1:0]    div_eff;
   logic [NUM_W-1:0]                num;
   logic [DEN_W-1:0]                den;
   logic                            div_start;
   logic                            div_done;
   logic [NUM_W-1:0]                quo;
   logic [QX_W-1:0]                 quo_x;
   logic [lcar_pkg::FORCE_W-1:0]    force_sat;
   logic                            read_end;

   // a new tick can enter while the previous result is being drained
   assign req_tready = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   lcar_serial #(
      .ADC_BITS (ADC_BITS)
   ) u_serial (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .req_type   (req_tuser),
      .dout_level (req_tdata[0]),
      .half_ticks (half_ff),
      .status     (status),
      .word       (word)
   );

   assign word_x   = RAW_X'(word);
   assign word_raw = word_x[lcar_pkg::RAW_W-1:0];
   assign read_end = req_accept && status.finish && !status.kind;

   // rounded divide: (net*20 + d) / (2*d), zero scale counts as one
   assign div_eff   = (scale_ff == '0) ? lcar_pkg::SCALE_W'(1) : scale_ff;
   assign num       = (NUM_W'(net_ff) << 4) + (NUM_W'(net_ff) << 2) + NUM_W'(div_eff);
   assign den       = {div_eff, 1'b0};
   assign div_start = (state_ff == S_PREP);

   lcar_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quo   (quo)
   );

   // saturate to the force field
   assign quo_x     = QX_W'(quo);
   assign force_sat = (quo_x > QX_W'({lcar_pkg::FORCE_W{1'b1}})) ? {lcar_pkg::FORCE_W{1'b1}}
                                                                  : quo_x[lcar_pkg::FORCE_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_RUN: begin
            if (read_end) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_RUN;
         scale_ff      <= lcar_pkg::SCALE_RESET;
         half_ff       <= lcar_pkg::HALF_RESET;
         tare_ff       <= '0;
         last_raw_ff   <= '0;
         last_force_ff <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_addr)
               lcar_pkg::CSR_SCALE: scale_ff <= csr_wdata;
               lcar_pkg::CSR_HALF:  half_ff  <= csr_wdata[lcar_pkg::HALF_W-1:0];
               default: begin
               end
            endcase
         end

         // a finished conversion updates the raw word; tare capture also stores it
         if (req_accept && status.finish) begin
            last_raw_ff <= word_raw;
            if (status.kind) begin
               tare_ff <= word;
            end
         end

         if (div_done) begin
            last_force_ff <= force_sat;
            error_ff      <= below_ff && (force_sat != '0);
         end

         // output transfer bookkeeping
         if ((req_accept && !read_end) || div_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (read_end) begin
         below_ff <= (word < tare_ff);
         net_ff   <= (word >= tare_ff) ? (word - tare_ff) : (tare_ff - word);
      end
      if (div_done) begin
         // the read ended with the clock low and the interface idle
         rsp_sck_ff   <= 1'b0;
         rsp_busy_ff  <= 1'b0;
         rsp_done_ff  <= 1'b1;
         rsp_tared_ff <= 1'b0;
         rsp_raw_ff   <= last_raw_ff;
         rsp_force_ff <= force_sat;
         rsp_err_ff   <= below_ff && (force_sat != '0);
      end else if (req_accept && !read_end) begin
         rsp_sck_ff   <= status.sck;
         rsp_busy_ff  <= status.busy;
         rsp_done_ff  <= 1'b0;
         rsp_tared_ff <= status.finish && status.kind;
         rsp_raw_ff   <= status.finish ? word_raw : last_raw_ff;
         rsp_force_ff <= last_force_ff;
         rsp_err_ff   <= error_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_err_ff, rsp_force_ff, rsp_raw_ff,
                        rsp_tared_ff, rsp_done_ff, rsp_busy_ff, rsp_sck_ff};

   // the divider only reports a quotient while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   // a tick that ends a force read always starts the divide
   a_read_starts_div: assert property (@(posedge clock) disable iff (reset)
      read_end |=> (state_ff == S_PREP))
      else $error("force read end did not start the divide");

   // a completed result leaves the interface idle with the clock low
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_done_ff || rsp_tared_ff)) |-> (!rsp_busy_ff && !rsp_sck_ff))
      else $error("completion reported while the interface is busy");

   // the error flag never stands with a zero force
   a_err_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_err_ff && (rsp_force_ff == '0)))
      else $error("weight error with zero force");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

   localparam int REQ_TYPE_W = lcar_pkg::REQ_TYPE_W;
   localparam int RAW_W      = lcar_pkg::RAW_W;
   localparam int FORCE_W    = lcar_pkg::FORCE_W;
   localparam int SCALE_W    = lcar_pkg::SCALE_W;
   localparam int HALF_W     = lcar_pkg::HALF_W;
   localparam int CSR_ADDR_W = lcar_pkg::CSR_ADDR_W;

   // request code outside the defined set, the block treats it as a plain tick
   localparam logic [REQ_TYPE_W-1:0] REQ_BAD = 2'd3;
   localparam logic [RAW_W-1:0] SIGN_BIT = RAW_W'(1) << (RAW_W - 1);
   localparam logic [63:0] FORCE_MAX = (64'd1 << FORCE_W) - 64'd1;
   // wait after the closing tick for the divider to finish, with some margin
   localparam int DRAIN_CYCLES = 48;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   // one tick result as packed on rsp_tdata, lowest field last
   typedef struct packed {
      logic [6:0]         pad;
      logic               weight_error;
      logic [FORCE_W-1:0] force_res;
      logic [RAW_W-1:0]   raw_code;
      logic               tare_done;
      logic               result_valid;
      logic               busy_res;
      logic               sck_level;
   } tick_result_type;

   typedef enum logic [1:0] {SER_IDLE, SER_WAIT, SER_HIGH, SER_LOW} ser_phase_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;               // [0] dout_level, [7:1] zero
   logic [REQ_TYPE_W-1:0] req_tuser;    // [1:0] req_type
   logic rsp_tvalid;
   logic rsp_tready;
   // [0] sck_level, [1] busy_res, [2] result_valid, [3] tare_done, [27:4] raw_code,
   // [55:28] force_res, [56] weight_error, [63:57] zero
   logic [63:0] rsp_tdata;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [SCALE_W-1:0] csr_wdata;

   load_cell_adc_reader_with_tare u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the serial reader: phase, counters, words and registers
   ser_phase_type      ph;
   logic               tare_pending;
   int unsigned        bits_taken;
   int unsigned        half_cnt;
   logic [RAW_W-1:0]   shreg;
   logic [RAW_W-1:0]   tare_word;
   logic [RAW_W-1:0]   raw_word;
   logic [FORCE_W-1:0] force_word;
   logic               err_word;
   logic [SCALE_W-1:0] scale_reg;
   logic [HALF_W-1:0]  half_reg;

   tick_result_type expected_ticks[$];
   int errors = 0;
   int unsigned ticks_sent = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int quiet_cycles_ff = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void reset_model();
      ph = SER_IDLE;
      tare_pending = 1'b0;
      bits_taken = 0;
      half_cnt = 0;
      shreg = '0;
      tare_word = '0;
      raw_word = '0;
      force_word = '0;
      err_word = 1'b0;
      scale_reg = lcar_pkg::SCALE_RESET;
      half_reg = lcar_pkg::HALF_RESET;
   endfunction

   // advance the shadow reader by one tick and return what the block should report
   function automatic tick_result_type predict_tick(input logic [REQ_TYPE_W-1:0] rt,
                                                    input logic dout);
      tick_result_type r;
      int unsigned half;
      logic [RAW_W-1:0] word;
      logic [63:0] div, net, q;
      r = '0;
      half = (half_reg == '0) ? 1 : 32'(half_reg);
      case (ph)
         SER_IDLE: begin
            if (rt == lcar_pkg::REQ_READ || rt == lcar_pkg::REQ_TARE) begin
               tare_pending = (rt == lcar_pkg::REQ_TARE);
               ph = SER_WAIT;
            end
         end
         SER_WAIT: begin
            // converter ready, first clock pulse goes high on this tick
            if (!dout) begin
               ph = SER_HIGH;
               half_cnt = 1;
               bits_taken = 0;
               shreg = '0;
            end
         end
         SER_HIGH: begin
            if (half_cnt >= half) begin
               ph = SER_LOW;
               half_cnt = 1;
            end else begin
               half_cnt++;
            end
         end
         default: begin
            if (half_cnt >= half) begin
               // data bit sampled at the end of the low half, msb first
               if (bits_taken < RAW_W) shreg = {shreg[RAW_W-2:0], dout};
               bits_taken++;
               if (bits_taken <= RAW_W) begin
                  ph = SER_HIGH;
                  half_cnt = 1;
               end else begin
                  // end of the extra pulse closes the operation
                  word = shreg ^ SIGN_BIT;
                  raw_word = word;
                  if (tare_pending) begin
                     tare_word = word;
                     r.tare_done = 1'b1;
                  end else begin
                     div = (scale_reg == '0) ? 64'd1 : 64'(scale_reg);
                     net = (word >= tare_word) ? 64'(word) - 64'(tare_word)
                                               : 64'(tare_word) - 64'(word);
                     // ten times net over scale, rounded half up
                     q = (net * 64'd20 + div) / (div * 64'd2);
                     if (q > FORCE_MAX) q = FORCE_MAX;
                     force_word = q[FORCE_W-1:0];
                     err_word = (word < tare_word) && (q != 64'd0);
                     r.result_valid = 1'b1;
                  end
                  ph = SER_IDLE;
                  bits_taken = 0;
                  half_cnt = 0;
               end
            end else begin
               half_cnt++;
            end
         end
      endcase
      r.sck_level = (ph == SER_HIGH);
      r.busy_res = (ph != SER_IDLE);
      r.raw_code = raw_word;
      r.force_res = force_word;
      r.weight_error = err_word;
      return r;
   endfunction

   // offer one tick, with random sender gaps, and hold it until the transfer
   task automatic send_tick(input logic [REQ_TYPE_W-1:0] rt, input logic dout);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = rt;
      req_tdata = {7'b0, dout};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_ticks.push_back(predict_tick(rt, dout));
      ticks_sent++;
   endtask

   // feed ticks until the shadow reader is idle again, pins carry the given bits
   task automatic finish_conversion(input logic [RAW_W-1:0] pins, input bit noisy);
      logic d;
      logic [REQ_TYPE_W-1:0] rt;
      while (ph != SER_IDLE) begin
         if (ph == SER_LOW && half_cnt >= ((half_reg == '0) ? 1 : 32'(half_reg)) &&
             bits_taken < RAW_W)
            d = pins[RAW_W-1-bits_taken];
         else if (ph == SER_WAIT)
            d = 1'b0;
         else
            d = 1'($urandom_range(1));
         // requests while busy should be ignored
         rt = noisy ? REQ_TYPE_W'($urandom_range(3)) : lcar_pkg::REQ_TICK;
         send_tick(rt, d);
      end
   endtask

   // one full read or tare capture; code is the offset binary word to be seen
   task automatic convert(input logic [REQ_TYPE_W-1:0] kind, input logic [RAW_W-1:0] code,
                          input int wait_ticks, input bit noisy);
      send_tick(kind, 1'($urandom_range(1)));
      // converter not ready yet
      repeat (wait_ticks)
         send_tick(noisy ? REQ_TYPE_W'($urandom_range(3)) : lcar_pkg::REQ_TICK, 1'b1);
      finish_conversion(code ^ SIGN_BIT, noisy);
   endtask

   // register write, only once the block has gone idle and every result is out
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [SCALE_W-1:0] data);
      finish_conversion(RAW_W'($urandom), 1'b0);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (addr == lcar_pkg::CSR_SCALE) scale_reg = data;
      else half_reg = data[HALF_W-1:0];
   endtask

   // scale spread over all magnitudes
   function automatic logic [SCALE_W-1:0] rand_scale();
      int unsigned sh;
      sh = $urandom_range(1, SCALE_W);
      return SCALE_W'($urandom_range(1, (32'd1 << sh) - 1));
   endfunction

   // word choice: random, close to the tare, or an extreme
   function automatic logic [RAW_W-1:0] rand_code();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 5) return RAW_W'($urandom);
      if (pick < 8) return tare_word + RAW_W'($urandom_range(64)) - RAW_W'(32);
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return SIGN_BIT;
         3: return ~SIGN_BIT;
         default: return tare_word;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // compare every result transfer with the oldest predicted tick
   always @(posedge clock) begin : check_results
      tick_result_type got;
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tick_result_type'(rsp_tdata);
         if (expected_ticks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("sck_level", 64'(want.sck_level), 64'(got.sck_level));
            check_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
            check_field("result_valid", 64'(want.result_valid), 64'(got.result_valid));
            check_field("tare_done", 64'(want.tare_done), 64'(got.tare_done));
            check_field("raw_code", 64'(want.raw_code), 64'(got.raw_code));
            check_field("force_res", 64'(want.force_res), 64'(got.force_res));
            check_field("weight_error", 64'(want.weight_error), 64'(got.weight_error));
            check_field("padding", 64'(want.pad), 64'(got.pad));
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin : drive_ready
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles_ff <= 0;
      end else begin
         quiet_cycles_ff <= quiet_cycles_ff + 1;
         if (quiet_cycles_ff >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // plain ticks and the undefined request code in idle
   task automatic test_plain_ticks();
      send_tick(lcar_pkg::REQ_TICK, 1'b0);
      send_tick(lcar_pkg::REQ_TICK, 1'b1);
      send_tick(REQ_BAD, 1'b0);
      send_tick(REQ_BAD, 1'b1);
   endtask

   // tare capture of the top code under the reset register values
   task automatic test_tare_capture();
      convert(lcar_pkg::REQ_TARE, '1, 1, 1'b0);
   endtask

   // below-tare error, zero result without error, rounding, zero scale
   task automatic test_scale_extremes();
      // one count below tare with the largest scale rounds to zero
      write_reg(lcar_pkg::CSR_SCALE, '1);
      convert(lcar_pkg::REQ_READ, '1 - RAW_W'(1), 0, 1'b0);
      // exactly half a unit rounds up
      write_reg(lcar_pkg::CSR_SCALE, SCALE_W'(20));
      convert(lcar_pkg::REQ_READ, '1 - RAW_W'(1), 0, 1'b0);
      // zero scale acts as one, largest net count
      write_reg(lcar_pkg::CSR_SCALE, '0);
      convert(lcar_pkg::REQ_READ, '0, 0, 1'b0);
      write_reg(lcar_pkg::CSR_SCALE, lcar_pkg::SCALE_RESET);
   endtask

   // zero half period acts as one, then a two-tick half period; busy requests mixed in
   task automatic test_half_period();
      write_reg(lcar_pkg::CSR_HALF, '0);
      convert(lcar_pkg::REQ_READ, RAW_W'($urandom), 1, 1'b1);
      write_reg(lcar_pkg::CSR_HALF, SCALE_W'(2));
      convert(lcar_pkg::REQ_TARE, RAW_W'($urandom), 1, 1'b1);
      write_reg(lcar_pkg::CSR_HALF, SCALE_W'(1));
   endtask

   // receiver holds off while the sender keeps offering, block must stall its input
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      repeat (8) send_tick(lcar_pkg::REQ_TICK, 1'($urandom_range(1)));
   endtask

   // whole conversions with random content, loose ticks in between
   task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                      input int unsigned n_conv);
      logic [REQ_TYPE_W-1:0] kind;
      gap_pct = gap;
      stall_pct = stall;
      write_reg(lcar_pkg::CSR_SCALE, rand_scale());
      repeat (n_conv) begin
         // loose ticks may start a sequence early
         repeat ($urandom_range(4))
            send_tick(REQ_TYPE_W'($urandom_range(3)), 1'($urandom_range(1)));
         kind = ($urandom_range(4) == 0) ? lcar_pkg::REQ_TARE : lcar_pkg::REQ_READ;
         convert(kind, rand_code(), $urandom_range(3), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = lcar_pkg::REQ_TICK;
      csr_we = 1'b0;
      csr_addr = lcar_pkg::CSR_SCALE;
      csr_wdata = '0;
      reset_model();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_plain_ticks();
      test_tare_capture();
      test_scale_extremes();
      test_half_period();
      test_backpressure();
      test_random_traffic(59, 0, 1);
      test_random_traffic(0, 59, 1);
      test_random_traffic(27, 27, 1);

      // stop offering and let the last results drain
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ load_cell_adc_reader_with_tare.f @@
rtl/lcar_pkg.sv
rtl/lcar_serial.sv
rtl/lcar_div.sv
rtl/load_cell_adc_reader_with_tare.sv
bench/tb_top.sv
